FILE: hw/rtl/wcmf_pkg.sv
`default_nettype none

package wcmf_pkg;

  localparam int unsigned CFG_W     = 11;
  localparam int unsigned THR_W     = 6;
  localparam int unsigned IDX_W     = 2;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned Q_DEPTH   = 4;
  localparam int unsigned OUT_DEPTH = 8;

  localparam logic [CFG_W-1:0] WIDTH_RST     = 11'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST    = 11'd480;
  localparam logic             TARGET_RST    = 1'b1;
  localparam logic [THR_W-1:0] THRESHOLD_RST = 6'd4;

  typedef enum logic [IDX_W-1:0] {
    CFG_WIDTH     = 2'd0,
    CFG_HEIGHT    = 2'd1,
    CFG_TARGET    = 2'd2,
    CFG_THRESHOLD = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic             target;
    logic [THR_W-1:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic pixel_value;
    logic drain;
  } in_item_t;

  typedef struct packed {
    logic out_pixel;
    logic last_of_frame;
  } out_item_t;

  // one raster step handed from the front to the back
  typedef struct packed {
    logic             pixel;
    logic [CFG_W-1:0] col;
    logic             emit;
    logic             last;
    logic [CFG_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
  } step_t;

endpackage

`default_nettype wire

FILE: hw/rtl/wcmf_queue.sv
`default_nettype none

module wcmf_queue
  import wcmf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  step_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output step_t head_o,
  output logic  empty_o
);

  localparam int unsigned PW = $clog2(Q_DEPTH);

  step_t         mem_q [Q_DEPTH];
  logic [PW-1:0] wr_ptr_q;
  logic [PW-1:0] rd_ptr_q;
  logic [PW:0]   cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("step queue written while full");

endmodule

`default_nettype wire

FILE: hw/rtl/wcmf_front.sv
`default_nettype none

module wcmf_front
  import wcmf_pkg::*;
#(
  parameter int unsigned RADIUS    = 4,
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t in_item_i,
  output logic     full_o,
  input  cfg_t     cfg_i,
  input  logic     restart_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output step_t    q_data_o
);

  localparam int unsigned DW = $clog2((RADIUS-1)*MAX_WIDTH + RADIUS);

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_SPIN = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [CFG_W-1:0] in_col_q, in_col_d;
  logic [CFG_W-1:0] out_col_q, out_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic [ROW_W-1:0] out_row_q, out_row_d;
  logic [DW-1:0]    steps_q, steps_d;
  logic [DW-1:0]    delay;
  logic             frame_in;
  logic             emit_now;
  logic             last_now;
  logic             accept;
  logic             step_req;
  logic             step_bit;

  // raster distance between a pixel and the result it completes
  assign delay    = DW'(RADIUS-1) * DW'(cfg_i.width) + DW'(RADIUS-1);
  assign frame_in = (in_row_q < ROW_W'(cfg_i.height));
  assign emit_now = (steps_q >= delay);
  assign last_now = emit_now && (out_col_q == cfg_i.width - CFG_W'(1))
                    && (out_row_q == ROW_W'(cfg_i.height) - ROW_W'(1));

  assign full_o = (state_q != ST_RUN) || q_full_i;
  assign accept = push_i && !full_o;

  always_comb begin
    state_d  = state_q;
    step_req = 1'b0;
    step_bit = 1'b0;
    unique case (state_q)
      ST_RUN: begin
        if (accept) begin
          if (frame_in) begin
            // a drain before the frame is complete is dropped
            step_req = !in_item_i.drain;
            step_bit = in_item_i.pixel_value;
          end else begin
            step_req = 1'b1;
            if (!emit_now) begin
              state_d = ST_SPIN;
            end
          end
        end
      end
      ST_SPIN: begin
        // small frame: run empty steps until the first result is due
        step_req = !q_full_i;
        if (step_req && emit_now) begin
          state_d = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    steps_d   = steps_q;
    if (step_req) begin
      if (in_col_q == cfg_i.width - CFG_W'(1)) begin
        in_col_d = '0;
        in_row_d = in_row_q + ROW_W'(1);
      end else begin
        in_col_d = in_col_q + CFG_W'(1);
      end
      if (emit_now) begin
        if (out_col_q == cfg_i.width - CFG_W'(1)) begin
          out_col_d = '0;
          out_row_d = out_row_q + ROW_W'(1);
        end else begin
          out_col_d = out_col_q + CFG_W'(1);
        end
      end else begin
        steps_d = steps_q + DW'(1);
      end
      if (last_now) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
        steps_d   = '0;
      end
    end
    if (restart_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
      steps_d   = '0;
    end
  end

  always_comb begin
    q_push_o         = step_req;
    q_data_o.pixel   = step_bit;
    q_data_o.col     = in_col_q;
    q_data_o.emit    = emit_now;
    q_data_o.last    = last_now;
    q_data_o.out_col = out_col_q;
    q_data_o.out_row = out_row_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_RUN;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      steps_q   <= '0;
    end else begin
      state_q   <= (restart_i || (step_req && last_now)) ? ST_RUN : state_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      steps_q   <= steps_d;
    end
  end

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push_o && q_data_o.last) |=> (in_col_q == '0 && in_row_q == '0 && steps_q == '0))
    else $error("frame counters not cleared after last result");

  a_lead_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= delay)
    else $error("lead counter ran past the window delay");

  a_spin_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SPIN) |-> !frame_in)
    else $error("flush steps issued while the frame is still arriving");

endmodule

`default_nettype wire

FILE: hw/rtl/wcmf_back.sv
`default_nettype none

module wcmf_back
  import wcmf_pkg::*;
#(
  parameter int unsigned RADIUS    = 4,
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_empty_i,
  input  step_t     q_head_i,
  output logic      q_pop_o,
  output logic      empty_o,
  input  logic      pop_i,
  output out_item_t out_item_o
);

  localparam int unsigned K     = 2*RADIUS - 1;
  localparam int unsigned LW    = 2*RADIUS - 2;
  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned PCW   = $clog2(K + 1);
  localparam int unsigned CNT_W = $clog2(K*K + 1);
  localparam int unsigned CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;
  localparam int unsigned OPW   = $clog2(OUT_DEPTH);
  localparam int unsigned OCW   = OPW + 1;
  localparam int unsigned EW    = CFG_W + 1;
  localparam int unsigned YW    = ROW_W + 1;

  // column store: per column the last LW rows, oldest in bit 0
  logic [LW-1:0] lb_mem [MAX_WIDTH];

  logic                  pop_ok;
  logic [OCW+1:0]        credit_use;
  logic [AW-1:0]         head_addr;
  logic [AW-1:0]         b_addr;
  logic                  b_valid_q;
  step_t                 b_step_q;
  logic [LW-1:0]         rd_word_q;
  logic [LW-1:0]         last_word_q;
  logic                  fwd_q;
  logic [LW-1:0]         cur_word;
  logic [LW-1:0]         new_word;
  logic [K-1:0]          col_vec;
  logic [K-1:0][K-1:0]   win_q;
  logic [K-1:0]          col_mask;
  logic [K-1:0]          row_mask;
  logic                  c_valid_q;
  logic                  c_last_q;
  logic [K-1:0]          c_col_mask_q;
  logic [K-1:0]          c_row_mask_q;
  logic [K-1:0][PCW-1:0] col_cnt;
  logic                  d_valid_q;
  logic                  d_last_q;
  logic                  d_centre_q;
  logic [K-1:0][PCW-1:0] d_cnt_q;
  logic [CNT_W-1:0]      win_cnt;
  logic                  fill;
  out_item_t             d_item;
  out_item_t             out_mem_q [OUT_DEPTH];
  logic [OPW-1:0]        owr_q;
  logic [OPW-1:0]        ord_q;
  logic [OCW-1:0]        ocnt_q;
  logic                  out_pop;

  // results in flight all have a slot reserved in the output buffer
  assign credit_use = (OCW+2)'(ocnt_q) + (OCW+2)'(b_valid_q && b_step_q.emit)
                      + (OCW+2)'(c_valid_q) + (OCW+2)'(d_valid_q);
  assign pop_ok     = !q_empty_i && (credit_use < (OCW+2)'(OUT_DEPTH));
  assign q_pop_o    = pop_ok;

  assign head_addr = AW'(q_head_i.col);
  assign b_addr    = AW'(b_step_q.col);

  // same column back to back (width one): take the word just written
  assign cur_word = fwd_q ? last_word_q : rd_word_q;
  assign new_word = {b_step_q.pixel, cur_word[LW-1:1]};
  assign col_vec  = {b_step_q.pixel, cur_word};

  always_comb begin
    logic [EW-1:0] xp;
    logic [YW-1:0] yp;
    xp = EW'(b_step_q.out_col) + EW'(RADIUS-1);
    yp = '0;
    for (int a = 0; a < K; a++) begin
      col_mask[a] = (xp >= EW'(a)) && ((xp - EW'(a)) < EW'(cfg_i.width));
    end
    for (int m = 0; m < K; m++) begin
      yp = YW'(b_step_q.out_row) + YW'(m);
      row_mask[m] = (yp >= YW'(RADIUS-1))
                    && ((yp - YW'(RADIUS-1)) < YW'(cfg_i.height));
    end
  end

  always_comb begin
    for (int a = 0; a < K; a++) begin
      col_cnt[a] = '0;
      for (int m = 0; m < K; m++) begin
        col_cnt[a] = col_cnt[a] + PCW'((win_q[a][m] == cfg_i.target)
                                        && c_col_mask_q[a] && c_row_mask_q[m]);
      end
    end
  end

  always_comb begin
    win_cnt = '0;
    for (int a = 0; a < K; a++) begin
      win_cnt = win_cnt + CNT_W'(d_cnt_q[a]);
    end
    fill = (d_centre_q == cfg_i.target)
           || (CMP_W'(win_cnt) >= CMP_W'(cfg_i.threshold));
    d_item.out_pixel     = fill ? cfg_i.target : d_centre_q;
    d_item.last_of_frame = d_last_q;
  end

  assign empty_o    = (ocnt_q == '0);
  assign out_item_o = out_mem_q[ord_q];
  assign out_pop    = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (pop_ok) begin
      rd_word_q <= lb_mem[head_addr];
      b_step_q  <= q_head_i;
    end
    if (b_valid_q) begin
      lb_mem[b_addr] <= new_word;
      last_word_q    <= new_word;
    end
    c_col_mask_q <= col_mask;
    c_row_mask_q <= row_mask;
    c_last_q     <= b_step_q.last;
    d_cnt_q      <= col_cnt;
    d_centre_q   <= win_q[RADIUS-1][RADIUS-1];
    d_last_q     <= c_last_q;
    if (d_valid_q) begin
      out_mem_q[owr_q] <= d_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      fwd_q     <= 1'b0;
      win_q     <= '0;
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
      owr_q     <= '0;
      ord_q     <= '0;
      ocnt_q    <= '0;
    end else begin
      b_valid_q <= pop_ok;
      if (pop_ok) begin
        fwd_q <= b_valid_q && (b_addr == head_addr);
      end
      if (b_valid_q) begin
        win_q <= {win_q[K-2:0], col_vec};
      end
      c_valid_q <= b_valid_q && b_step_q.emit;
      d_valid_q <= c_valid_q;
      if (d_valid_q) begin
        owr_q <= owr_q + OPW'(1);
      end
      if (out_pop) begin
        ord_q <= ord_q + OPW'(1);
      end
      ocnt_q <= ocnt_q + OCW'(d_valid_q) - OCW'(out_pop);
    end
  end

  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_valid_q |-> (ocnt_q < OCW'(OUT_DEPTH) || out_pop))
    else $error("result buffer overrun");

  a_fwd_follows_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && fwd_q) |-> $past(b_valid_q))
    else $error("column word bypass without a preceding write");

endmodule

`default_nettype wire

FILE: hw/rtl/window_count_mask_fill.sv
// channel  | handshake       | payload      | transfer when
// ---------+-----------------+--------------+-------------------------------
// input    | push / full     | in_item_i    | push && !full at clk_i rise
// result   | empty / pop     | out_item_o   | pop && !empty at clk_i rise
// config   | cfg_we_i        | cfg_idx_i,   | cfg_we_i at clk_i rise
//          |                 | cfg_wdata_i  |
//
// One pixel per cycle while the step queue has room and no spin runs; a result
// passes the step queue, column store read, window shift, per-column count, and
// window sum and compare after the transfer that completes its window.
// The first item after the last pixel of a frame with fewer than (RADIUS-1)*(width+1)
// pixels, drain or pixel, starts a spin of empty steps that holds full until the
// first result is due, longer while the step queue is full.
// Reset clears counters and queues at once; the column store is not cleared.
// Either side may stall freely: a step queue and an eight-entry result
// buffer decouple them.
`default_nettype none

module window_count_mask_fill
  import wcmf_pkg::*;
#(
  parameter int unsigned RADIUS    = 4,
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  in_item_t         in_item_i,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output out_item_t        out_item_o,
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  cfg_t  cfg_q;
  logic  restart;
  logic  q_push;
  step_t q_data;
  logic  q_full;
  logic  q_pop;
  step_t q_head;
  logic  q_empty;

  function automatic logic [CFG_W-1:0] clamp_width(logic [CFG_W-1:0] w);
    logic [CFG_W-1:0] r;
    r = w;
    if (w == '0) begin
      r = CFG_W'(1);
    end else if (32'(w) > 32'(MAX_WIDTH)) begin
      r = CFG_W'(MAX_WIDTH);
    end
    return r;
  endfunction

  // a size write starts a new frame
  assign restart = cfg_we_i && ((cfg_idx_e'(cfg_idx_i) == CFG_WIDTH)
                                || (cfg_idx_e'(cfg_idx_i) == CFG_HEIGHT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width     <= clamp_width(WIDTH_RST);
      cfg_q.height    <= HEIGHT_RST;
      cfg_q.target    <= TARGET_RST;
      cfg_q.threshold <= THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:     cfg_q.width     <= clamp_width(cfg_wdata_i);
        CFG_HEIGHT:    cfg_q.height    <= (cfg_wdata_i == '0) ? CFG_W'(1) : cfg_wdata_i;
        CFG_TARGET:    cfg_q.target    <= cfg_wdata_i[0];
        CFG_THRESHOLD: cfg_q.threshold <= cfg_wdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  wcmf_front #(
    .RADIUS    (RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_item_i (in_item_i),
    .full_o    (full),
    .cfg_i     (cfg_q),
    .restart_i (restart),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_data)
  );

  wcmf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty)
  );

  wcmf_back #(
    .RADIUS    (RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .q_pop_o    (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

FILE: verif/testbench.sv
module testbench;
  import wcmf_pkg::*;

  localparam int RAD       = 4;
  localparam int MAXW      = 1024;
  localparam int RING_SIZE = 2 * RAD * MAXW;

  // expected filtered mask, worked out pixel by pixel from the unfiltered input
  class mask_fill_board;
    bit               mask_bits [RING_SIZE];
    int               col_in, row_in, out_pos;
    int               frames_done, fail_count, seen_count;
    logic [CFG_W-1:0] width_reg  = WIDTH_RST;
    logic [CFG_W-1:0] height_reg = HEIGHT_RST;
    logic             target_reg = TARGET_RST;
    logic [THR_W-1:0] thr_reg    = THRESHOLD_RST;
    out_item_t        pending_fill [$];

    function int cols();
      int w;
      w = int'(width_reg);
      if (w == 0) w = 1;
      if (w > MAXW) w = MAXW;
      return w;
    endfunction

    function int rows();
      return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    function void restart();
      col_in  = 0;
      row_in  = 0;
      out_pos = 0;
    endfunction

    function bit fill_at(int pos, int w, int h);
      int i, j, hits;
      bit centre;
      i = pos / w;
      j = pos % w;
      hits = 0;
      centre = mask_bits[(i * w + j) % RING_SIZE];
      if (centre == target_reg) return centre;
      // window positions outside the image never match
      for (int r = i - (RAD - 1); r <= i + RAD - 1; r++)
        for (int c = j - (RAD - 1); c <= j + RAD - 1; c++)
          if (r >= 0 && r < h && c >= 0 && c < w)
            if (mask_bits[(r * w + c) % RING_SIZE] == target_reg) hits++;
      return (hits >= thr_reg) ? target_reg : centre;
    endfunction

    function void emit(int w, int h);
      out_item_t res;
      res.out_pixel     = fill_at(out_pos, w, h);
      res.last_of_frame = (out_pos == w * h - 1);
      pending_fill.push_back(res);
      out_pos++;
      if (res.last_of_frame) begin
        restart();
        frames_done++;
      end
    endfunction

    function void note_item(in_item_t it);
      int w, h, total, lag, got;
      w     = cols();
      h     = rows();
      total = w * h;
      lag   = (RAD - 1) * w + (RAD - 1);
      got   = row_in * w + col_in;
      if (!it.drain && got < total) begin
        mask_bits[got % RING_SIZE] = it.pixel_value;
        col_in++;
        if (col_in >= w) begin
          col_in = 0;
          row_in++;
        end
        got++;
        if (got > lag && out_pos < got) emit(w, h);
      end else if (got >= total && out_pos < total) begin
        // drains, and pixels past the frame end, push out pending results
        emit(w, h);
      end
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_WIDTH: begin
          width_reg = val;
          restart();
        end
        CFG_HEIGHT: begin
          height_reg = val;
          restart();
        end
        CFG_TARGET:    target_reg = val[0];
        CFG_THRESHOLD: thr_reg = val[THR_W-1:0];
        default: ;
      endcase
    endfunction

    task report(string msg);
      fail_count++;
      if (fail_count <= 100) $display("mismatch at result %0d: %s", seen_count, msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      seen_count++;
      if (pending_fill.size() == 0) begin
        report($sformatf("result %b with nothing expected", got));
      end else begin
        want = pending_fill.pop_front();
        if (got.out_pixel !== want.out_pixel)
          report($sformatf("out_pixel %b, expected %b", got.out_pixel, want.out_pixel));
        if (got.last_of_frame !== want.last_of_frame)
          report($sformatf("last_of_frame %b, expected %b",
                           got.last_of_frame, want.last_of_frame));
      end
    endtask
  endclass

  logic             clk;
  logic             rst_n;
  logic             push;
  logic             full;
  logic             empty;
  logic             pop;
  logic             cfg_we;
  in_item_t         in_item;
  out_item_t        out_item;
  cfg_idx_e         cfg_idx;
  logic [CFG_W-1:0] cfg_wdata;

  mask_fill_board board;
  bit             burst;
  int             hold_cycles;

  window_count_mask_fill #(
    .RADIUS   (RAD),
    .MAX_WIDTH(MAXW)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .in_item_i  (in_item),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int idle_gap();
    return burst ? 0 : int'($urandom_range(0, 5));
  endfunction

  // called at a rising edge; returns at the edge of the transfer, push left high
  task automatic send_item(input in_item_t it);
    int gap;
    bit taken;
    gap = idle_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= it;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end
    board.note_item(it);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // sender holds off until every expected result is in, then lets the pipe settle
  task automatic drain_wait();
    push <= 1'b0;
    do @(posedge clk); while (board.pending_fill.size() != 0);
    repeat (32) @(posedge clk);
  endtask

  // finish the frame with drains, some of them plain pixels that act as drains
  task automatic flush_frame();
    int mark;
    in_item_t it;
    mark = board.frames_done;
    while (board.frames_done == mark) begin
      it.drain       = ($urandom_range(0, 3) != 0);
      it.pixel_value = 1'($urandom_range(0, 1));
      send_item(it);
    end
  endtask

  // result side: stalls per transfer, plus one long hold-off on request
  initial begin : result_side
    int stall;
    bit taken;
    out_item_t seen;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        stall = hold_cycles;
        hold_cycles = 0;
      end else begin
        stall = idle_gap();
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
        @(negedge clk);
        taken = !empty;
        seen = out_item;
        @(posedge clk);
      end
      board.check_result(seen);
    end
  end

  initial begin : stimulus
    int k, total, stop_at, pause_at, ones_pct, frame_no, counted;
    bit abort, fixed_size;
    int wcfg, hcfg;
    in_item_t it;
    logic [CFG_W-1:0] cfg_val;
    logic [5:0] pattern;

    board       = new;
    push        = 1'b0;
    pop         = 1'b0;
    in_item     = '0;
    cfg_we      = 1'b0;
    cfg_idx     = CFG_WIDTH;
    cfg_wdata   = '0;
    burst       = 1'b0;
    hold_cycles = 0;
    rst_n       = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // small frame, threshold zero, early drain and a pixel past the frame end
    write_reg(CFG_WIDTH, 11'd3);
    write_reg(CFG_HEIGHT, 11'd2);
    write_reg(CFG_TARGET, 11'd1);
    write_reg(CFG_THRESHOLD, 11'd0);
    send_item('{pixel_value: 1'b1, drain: 1'b1});
    pattern = 6'b100101;
    for (k = 0; k < 6; k++) send_item('{pixel_value: pattern[k], drain: 1'b0});
    send_item('{pixel_value: 1'b1, drain: 1'b0});
    flush_frame();

    // zero sizes act as 1x1, top threshold, target zero
    drain_wait();
    write_reg(CFG_WIDTH, 11'd0);
    write_reg(CFG_HEIGHT, 11'd0);
    write_reg(CFG_TARGET, 11'd0);
    write_reg(CFG_THRESHOLD, 11'd63);
    send_item('{pixel_value: 1'b1, drain: 1'b0});
    flush_frame();

    // size write in the middle of a frame drops it
    drain_wait();
    write_reg(CFG_WIDTH, 11'd4);
    write_reg(CFG_HEIGHT, 11'd4);
    write_reg(CFG_TARGET, 11'd1);
    write_reg(CFG_THRESHOLD, 11'd2);
    for (k = 0; k < 8; k++) send_item('{pixel_value: k[0], drain: 1'b0});
    drain_wait();
    write_reg(CFG_HEIGHT, 11'd4);

    frame_no = 0;
    counted  = 0;
    while (counted < 750) begin
      drain_wait();
      frame_no++;
      burst      = ($urandom_range(0, 3) == 0);
      fixed_size = 1'b1;
      if (frame_no == 4) begin
        wcfg  = 2047;
        hcfg  = 1;
        burst = 1'b1;
      end else if (frame_no == 9) begin
        wcfg  = 1;
        hcfg  = 2047;
        burst = 1'b1;
      end else if (frame_no == 6) begin
        // receiver stops for a long stretch while pixels keep coming
        wcfg        = 12;
        hcfg        = 9;
        burst       = 1'b1;
        hold_cycles = 200;
      end else begin
        fixed_size = 1'b0;
        wcfg = $urandom_range(0, 12);
        hcfg = $urandom_range(0, 9);
      end
      write_reg(CFG_WIDTH, CFG_W'(wcfg));
      write_reg(CFG_HEIGHT, CFG_W'(hcfg));
      if ($urandom_range(0, 1)) begin
        cfg_val = CFG_W'($urandom);
        write_reg(CFG_TARGET, cfg_val);
      end
      if ($urandom_range(0, 1)) begin
        cfg_val = CFG_W'($urandom);
        if ($urandom_range(0, 4) != 0) cfg_val[THR_W-1:0] = THR_W'($urandom_range(0, 10));
        write_reg(CFG_THRESHOLD, cfg_val);
      end

      total    = board.cols() * board.rows();
      ones_pct = 10 + 40 * $urandom_range(0, 2);
      abort    = !fixed_size && total > 1 && ($urandom_range(0, 7) == 0);
      stop_at  = abort ? int'($urandom_range(1, total - 1)) : total;
      pause_at = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, stop_at - 1)) : -1;
      for (k = 0; k < stop_at; k++) begin
        if (k == pause_at) begin
          push <= 1'b0;
          do @(posedge clk); while (board.pending_fill.size() != 0);
        end
        if ($urandom_range(0, 19) == 0) begin
          it.drain       = 1'b1;
          it.pixel_value = 1'($urandom_range(0, 1));
          send_item(it);
        end
        it.drain       = 1'b0;
        it.pixel_value = ($urandom_range(0, 99) < ones_pct);
        send_item(it);
      end
      if (abort) begin
        drain_wait();
        cfg_val = $urandom_range(0, 1) ? board.width_reg : board.height_reg;
        write_reg($urandom_range(0, 1) ? CFG_WIDTH : CFG_HEIGHT, cfg_val);
      end else begin
        flush_frame();
      end
      if (!fixed_size) counted += stop_at;
    end
    burst = 1'b0;
    drain_wait();

    if (board.fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/wcmf_pkg.sv
hw/rtl/wcmf_queue.sv
hw/rtl/wcmf_front.sv
hw/rtl/wcmf_back.sv
hw/rtl/window_count_mask_fill.sv
verif/testbench.sv
